>>> rtl/core/page_run_frame_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Page run frame allocator assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_RUN_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_RUN_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define PRFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication
`define PRFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> rtl/core/prfa_pkg.sv
// ----------------------------------------------------------------------------
// Page run frame allocator package
// Status codes, state encoding and fixed field widths.
// ----------------------------------------------------------------------------
package prfa_pkg;

    localparam int STATUS_W = 3;
    localparam int VPAGE_W  = 20;
    localparam int FRAME_W  = 13;
    localparam int FREE_W   = 14;
    localparam int BYTES_W  = 32;
    localparam int OFFS_W   = 12;

    localparam logic [FRAME_W-1:0] FIRST_FRAME_RST = 13'd2304;
    localparam logic [VPAGE_W-1:0] WIN_BASE_RST    = 20'd786432;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEMORY = 3'd3,
        ST_FRAGMENT  = 3'd4,
        ST_PHYS_EXH  = 3'd5
    } status_t;

    typedef enum logic {
        CFG_FIRST_FRAME = 1'b0,
        CFG_WIN_BASE    = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_VSCAN,
        FSM_PSCAN,
        FSM_CRD,
        FSM_CWR,
        FSM_ERR
    } fsm_t;

endpackage

>>> rtl/core/page_run_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// Page run frame allocator
// Rounds a byte request up to 4 KiB frames, finds the lowest free run of
// virtual pages in the window, picks physical frames first-fit upward from
// the configured frame, and emits one mapping per page, highest page first.
//
// Usage: s_tdata carries request_bytes; a transfer on s_* starts a request.
// Results leave on m_*: m_tdata holds status, virtual_page, physical_frame,
// run_start, run_end; m_tlast marks the final result of a request. Errors
// give a single result with tlast set and leave the state untouched.
// Configuration (cfg_valid/cfg_index/cfg_data) is taken every cycle.
// Sequence: a request walks the virtual bitmap one page a cycle up to the end
// of its run, then the physical bitmap one frame a cycle from the first
// usable frame, then reads the picked frame (CRD) and marks both bitmaps
// (CWR) for each mapped page, waiting in CWR while the output is blocked;
// each bitmap memory has a single port. Input errors go through FSM_ERR.
// Reset: a clearing pass over max(WINDOW_PAGES, PHYS_FRAMES) entries zeroes
// both bitmaps; no request is taken meanwhile. A stalled receiver holds the
// output register and the sequencer waits on it; the next request is taken
// as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
module page_run_frame_allocator_unit
    import prfa_pkg::*;
#(
    parameter int PHYS_FRAMES  = 8192,
    parameter int WINDOW_PAGES = 4096,
    parameter int MAX_RUN      = 64
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] request_bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [2:0] status, [22:3] virtual_page,
                                    // [35:23] physical_frame, [36] run_start,
                                    // [37] run_end, [39:38] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int VA_W   = $clog2(WINDOW_PAGES);
    localparam int PA_W   = $clog2(PHYS_FRAMES);
    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam int PK_W   = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int CLR_N  = (WINDOW_PAGES > PHYS_FRAMES) ? WINDOW_PAGES : PHYS_FRAMES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam logic [VA_W:0]     WIN_END  = (VA_W + 1)'(WINDOW_PAGES);
    localparam logic [FREE_W-1:0] PHYS_END = FREE_W'(PHYS_FRAMES);

    // Bitmap and pick memories
    logic vmem [WINDOW_PAGES];
    logic pmem [PHYS_FRAMES];
    logic [FRAME_W-1:0] pick_mem [MAX_RUN];

    fsm_t state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [RUN_W-1:0]   frames_reg, frames_next;
    status_t            err_reg, err_next;
    logic [VA_W:0]      vaddr_reg, vaddr_next;
    logic               vrd_valid_reg, vrd_valid_next;
    logic [VA_W-1:0]    vrd_idx_reg, vrd_idx_next;
    logic [RUN_W-1:0]   run_len_reg, run_len_next;
    logic [VA_W-1:0]    run_first_reg, run_first_next;
    logic [FREE_W-1:0]  paddr_reg, paddr_next;
    logic               prd_valid_reg, prd_valid_next;
    logic [FRAME_W-1:0] prd_idx_reg, prd_idx_next;
    logic [RUN_W-1:0]   npicked_reg, npicked_next;
    logic [RUN_W-1:0]   k_reg, k_next;
    logic [FREE_W-1:0]  free_reg, free_next;
    logic [FRAME_W-1:0] first_frame_reg, first_frame_next;
    logic [VPAGE_W-1:0] win_base_reg, win_base_next;
    logic               out_valid_reg, out_valid_next;
    logic [39:0]        out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic               vmem_rd_reg, pmem_rd_reg;
    logic [FRAME_W-1:0] pick_rd_reg;

    // Memory port controls
    logic               vmem_we, vmem_wd, pmem_we, pmem_wd, pick_we;
    logic [VA_W-1:0]    vmem_addr;
    logic [PA_W-1:0]    pmem_addr;
    logic [PK_W-1:0]    pick_addr;
    logic [FRAME_W-1:0] pick_wd;

    logic [20:0]        req_frames;
    logic               slot_free;
    logic [VA_W-1:0]    widx;
    logic [RUN_W-1:0]   run_len_inc;

    assign s_tready  = (state_reg == FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    assign req_frames  = {1'b0, s_tdata[BYTES_W-1:OFFS_W]} + 21'(|s_tdata[OFFS_W-1:0]);
    assign slot_free   = !out_valid_reg || m_tready;
    assign widx        = run_first_reg + VA_W'(frames_reg) - VA_W'(k_reg) - VA_W'(1);
    assign run_len_inc = run_len_reg + RUN_W'(1);

    // Sequencer: next state, memory controls and result
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        frames_next      = frames_reg;
        err_next         = err_reg;
        vaddr_next       = vaddr_reg;
        vrd_valid_next   = 1'b0;
        vrd_idx_next     = vrd_idx_reg;
        run_len_next     = run_len_reg;
        run_first_next   = run_first_reg;
        paddr_next       = paddr_reg;
        prd_valid_next   = 1'b0;
        prd_idx_next     = prd_idx_reg;
        npicked_next     = npicked_reg;
        k_next           = k_reg;
        free_next        = free_reg;
        first_frame_next = first_frame_reg;
        win_base_next    = win_base_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        vmem_we          = 1'b0;
        vmem_wd          = 1'b0;
        vmem_addr        = vaddr_reg[VA_W-1:0];
        pmem_we          = 1'b0;
        pmem_wd          = 1'b0;
        pmem_addr        = paddr_reg[PA_W-1:0];
        pick_we          = 1'b0;
        pick_addr        = npicked_reg[PK_W-1:0];
        pick_wd          = prd_idx_reg;

        // Take configuration writes
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FIRST_FRAME: first_frame_next = cfg_data[FRAME_W-1:0];
                CFG_WIN_BASE:    win_base_next    = cfg_data;
                default:         win_base_next    = win_base_reg;
            endcase
        end

        case (state_reg)
            FSM_CLEAR:
            begin
                // Zero one entry of each bitmap per cycle
                vmem_addr = clr_reg[VA_W-1:0];
                pmem_addr = clr_reg[PA_W-1:0];
                vmem_we   = ({1'b0, clr_reg} < (CLR_W + 1)'(WINDOW_PAGES));
                pmem_we   = ({1'b0, clr_reg} < (CLR_W + 1)'(PHYS_FRAMES));
                clr_next  = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_N - 1))
                    state_next = FSM_IDLE;
            end
            FSM_IDLE:
            begin
                // Screen the request size, then start the window scan or go to the error state
                if (s_tvalid)
                begin
                    vaddr_next   = '0;
                    run_len_next = '0;
                    paddr_next   = FREE_W'(first_frame_reg);
                    npicked_next = '0;
                    k_next       = '0;
                    frames_next  = req_frames[RUN_W-1:0];
                    if (req_frames == 21'd0)
                    begin
                        err_next   = ST_ZERO_SIZE;
                        state_next = FSM_ERR;
                    end
                    else if (req_frames > 21'(MAX_RUN))
                    begin
                        err_next   = ST_TOO_LARGE;
                        state_next = FSM_ERR;
                    end
                    else if (req_frames > 21'(free_reg))
                    begin
                        err_next   = ST_NO_MEMORY;
                        state_next = FSM_ERR;
                    end
                    else
                        state_next = FSM_VSCAN;
                end
            end
            FSM_VSCAN:
            begin
                // Issue the next page read
                if (vaddr_reg < WIN_END)
                begin
                    vrd_valid_next = 1'b1;
                    vrd_idx_next   = vaddr_reg[VA_W-1:0];
                    vaddr_next     = vaddr_reg + (VA_W + 1)'(1);
                end
                // Track the run with the page read last cycle
                if (vrd_valid_reg)
                begin
                    if (vmem_rd_reg)
                        run_len_next = '0;
                    else
                    begin
                        if (run_len_reg == '0)
                            run_first_next = vrd_idx_reg;
                        run_len_next = run_len_inc;
                        if (run_len_inc == frames_reg)
                        begin
                            vrd_valid_next = 1'b0;
                            state_next     = FSM_PSCAN;
                        end
                    end
                end
                else if (vaddr_reg >= WIN_END)
                begin
                    err_next   = ST_FRAGMENT;
                    state_next = FSM_ERR;
                end
            end
            FSM_PSCAN:
            begin
                if (npicked_reg == frames_reg)
                begin
                    state_next = FSM_CRD;
                end
                else
                begin
                    if (paddr_reg < PHYS_END)
                    begin
                        prd_valid_next = 1'b1;
                        prd_idx_next   = paddr_reg[FRAME_W-1:0];
                        paddr_next     = paddr_reg + FREE_W'(1);
                    end
                    // Record a free frame from last cycle's read
                    if (prd_valid_reg)
                    begin
                        if (!pmem_rd_reg)
                        begin
                            pick_we      = 1'b1;
                            npicked_next = npicked_reg + RUN_W'(1);
                        end
                    end
                    else if (paddr_reg >= PHYS_END)
                    begin
                        err_next   = ST_PHYS_EXH;
                        state_next = FSM_ERR;
                    end
                end
            end
            FSM_CRD:
            begin
                // Fetch the frame for this page
                pick_addr  = k_reg[PK_W-1:0];
                state_next = FSM_CWR;
            end
            FSM_CWR:
            begin
                // Keep the frame read steady while the output is blocked
                pick_addr = k_reg[PK_W-1:0];
                // Mark both bitmaps and emit one mapping
                if (slot_free)
                begin
                    vmem_addr      = widx;
                    vmem_we        = 1'b1;
                    vmem_wd        = 1'b1;
                    pmem_addr      = pick_rd_reg[PA_W-1:0];
                    pmem_we        = 1'b1;
                    pmem_wd        = 1'b1;
                    out_valid_next = 1'b1;
                    out_last_next  = (k_reg == frames_reg - RUN_W'(1));
                    out_data_next  = {2'b00, (k_reg == '0),
                                      (k_reg == frames_reg - RUN_W'(1)),
                                      pick_rd_reg,
                                      win_base_reg + VPAGE_W'(widx),
                                      ST_OK};
                    if (k_reg == frames_reg - RUN_W'(1))
                    begin
                        free_next  = free_reg - FREE_W'(frames_reg);
                        state_next = FSM_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + RUN_W'(1);
                        state_next = FSM_CRD;
                    end
                end
            end
            FSM_ERR:
            begin
                // Emit the single error result
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_data_next  = {37'd0, err_reg};
                    state_next     = FSM_IDLE;
                end
            end
            default:
                state_next = FSM_IDLE;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_CLEAR;
            clr_reg         <= '0;
            vrd_valid_reg   <= 1'b0;
            prd_valid_reg   <= 1'b0;
            free_reg        <= FREE_W'(PHYS_FRAMES);
            first_frame_reg <= FIRST_FRAME_RST;
            win_base_reg    <= WIN_BASE_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            vrd_valid_reg   <= vrd_valid_next;
            prd_valid_reg   <= prd_valid_next;
            free_reg        <= free_next;
            first_frame_reg <= first_frame_next;
            win_base_reg    <= win_base_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frames_reg    <= frames_next;
        err_reg       <= err_next;
        vaddr_reg     <= vaddr_next;
        vrd_idx_reg   <= vrd_idx_next;
        run_len_reg   <= run_len_next;
        run_first_reg <= run_first_next;
        paddr_reg     <= paddr_next;
        prd_idx_reg   <= prd_idx_next;
        npicked_reg   <= npicked_next;
        k_reg         <= k_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    // Virtual page bitmap
    always_ff @(posedge clk)
    begin
        if (vmem_we)
            vmem[vmem_addr] <= vmem_wd;
        vmem_rd_reg <= vmem[vmem_addr];
    end

    // Physical frame bitmap
    always_ff @(posedge clk)
    begin
        if (pmem_we)
            pmem[pmem_addr] <= pmem_wd;
        pmem_rd_reg <= pmem[pmem_addr];
    end

    // Picked frame list
    always_ff @(posedge clk)
    begin
        if (pick_we)
            pick_mem[pick_addr] <= pick_wd;
        pick_rd_reg <= pick_mem[pick_addr];
    end

`include "page_run_frame_allocator_unit_assert.svh"

    `PRFA_ASSERT_SAME(a_pick_bound, state_reg == FSM_PSCAN, npicked_reg <= frames_reg)
    `PRFA_ASSERT_SAME(a_run_bound, state_reg == FSM_VSCAN, run_len_reg < frames_reg)
    `PRFA_ASSERT_NEXT(a_map_emit, state_reg == FSM_CWR && slot_free, m_tvalid)

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Page run frame allocator testbench
// Drives byte requests and register writes, predicts each mapping result
// with a bitmap model of its own, and checks every result transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
    import prfa_pkg::*;
();

    localparam int NUM_FRAMES  = 8192;
    localparam int NUM_PAGES   = 4096;
    localparam int RUN_MAX     = 64;
    localparam int SETTLE      = 16000;
    localparam int WDOG_LIMIT  = 200000;

    typedef struct packed {
        status_t            status;
        logic [VPAGE_W-1:0] vpage;
        logic [FRAME_W-1:0] frame;
        logic               run_start;
        logic               run_end;
        logic               last;
    } mapping_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [19:0] cfg_data;

    // Model state
    bit                 page_taken [NUM_PAGES];
    bit                 frame_taken[NUM_FRAMES];
    logic [FREE_W-1:0]  free_count;
    logic [FRAME_W-1:0] first_frame;
    logic [VPAGE_W-1:0] win_base;

    mapping_t pending_maps[$];
    int       err_count;
    int       idle_cycles;

    page_run_frame_allocator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Push one error result
    function automatic void push_error(status_t code);
        mapping_t m;
        m = '0;
        m.status = code;
        m.last   = 1'b1;
        pending_maps.push_back(m);
    endfunction

    // Work out the mappings that one request produces and update the bitmaps
    function automatic void predict_allocation(logic [31:0] nbytes);
        int       nframes;
        int       run_len;
        int       run_first;
        int       picked[$];
        bit       found;
        int       widx;
        mapping_t m;
        nframes   = int'(nbytes >> 12) + ((nbytes[11:0] != 0) ? 1 : 0);
        run_len   = 0;
        run_first = 0;
        found     = 0;
        if (nframes == 0)
        begin
            push_error(ST_ZERO_SIZE);
            return;
        end
        if (nframes > RUN_MAX)
        begin
            push_error(ST_TOO_LARGE);
            return;
        end
        if (nframes > free_count)
        begin
            push_error(ST_NO_MEMORY);
            return;
        end
        for (int i = 0; i < NUM_PAGES && !found; i++)
        begin
            if (page_taken[i])
                run_len = 0;
            else
            begin
                if (run_len == 0)
                    run_first = i;
                run_len++;
                if (run_len == nframes)
                    found = 1;
            end
        end
        if (!found)
        begin
            push_error(ST_FRAGMENT);
            return;
        end
        for (int f = first_frame; f < NUM_FRAMES && picked.size() < nframes; f++)
            if (!frame_taken[f])
                picked.push_back(f);
        if (picked.size() < nframes)
        begin
            push_error(ST_PHYS_EXH);
            return;
        end
        for (int k = 0; k < nframes; k++)
        begin
            widx = run_first + nframes - 1 - k;
            page_taken[widx]        = 1;
            frame_taken[picked[k]]  = 1;
            m.status    = ST_OK;
            m.vpage     = win_base + VPAGE_W'(widx);
            m.frame     = FRAME_W'(picked[k]);
            m.run_start = (k == nframes - 1);
            m.run_end   = (k == 0);
            m.last      = (k == nframes - 1);
            pending_maps.push_back(m);
        end
        free_count = free_count - FREE_W'(nframes);
    endfunction

    // Send one request after a random gap; valid drops only across a gap
    task automatic send_request(logic [31:0] nbytes);
        int gap;
        gap = $urandom_range(19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= nbytes;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_allocation(nbytes);
    endtask

    // Drop the request, wait for every expected result, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, logic [19:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_FIRST_FRAME)
            first_frame = value[FRAME_W-1:0];
        else
            win_base = value;
        cfg_valid <= 1'b0;
    endtask

    // Random size, mostly small runs with a few edge sizes
    function automatic logic [31:0] random_bytes();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return 32'(RUN_MAX) * 4096 - $urandom_range(4095);
            2:       return 32'(RUN_MAX) * 4096 + 1 + $urandom_range(4095);
            default: return $urandom_range(8 * 4096, 1);
        endcase
    endfunction

    task automatic test_edge_sizes();
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd4096);
        send_request(32'd4097);
        send_request(32'(RUN_MAX) * 4096);
        send_request(32'(RUN_MAX) * 4096 + 1);
        send_request(32'hFFFF_FFFF);
        send_request(32'hAAAA_AAAA);
        send_request(32'h0001_5555);
        drain_results();
    endtask

    task automatic test_window_extremes();
        write_register(CFG_WIN_BASE, 20'hFFFFF - 20);
        write_register(CFG_FIRST_FRAME, 20'd0);
        for (int i = 0; i < 5; i++)
            send_request($urandom_range(16 * 4096, 1));
        write_register(CFG_WIN_BASE, 20'd0);
        send_request(32'd12000);
        drain_results();
    endtask

    task automatic test_phys_exhausted();
        write_register(CFG_FIRST_FRAME, 20'h1FFF);
        send_request(32'd4096);
        send_request(32'd8192);
        write_register(CFG_FIRST_FRAME, 20'd8192 - 40);
        send_request(32'd60 * 4096);
        send_request(32'd30 * 4096);
        send_request(32'd20 * 4096);
        drain_results();
    endtask

    // Fill the window with maximum-size runs until it fragments
    task automatic test_fragmentation();
        write_register(CFG_FIRST_FRAME, 20'd0);
        write_register(CFG_WIN_BASE, 20'hC0000);
        for (int i = 0; i < 70; i++)
            send_request(32'd64 * 4096);
        send_request(32'd4096);
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 60; i++)
            send_request(random_bytes());
        drain_results();
    endtask

    // In-order check of results
    always @(posedge clk)
    begin
        mapping_t got;
        mapping_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = status_t'(m_tdata[2:0]);
            got.vpage     = m_tdata[22:3];
            got.frame     = m_tdata[35:23];
            got.run_start = m_tdata[36];
            got.run_end   = m_tdata[37];
            got.last      = m_tlast;
            if (pending_maps.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = pending_maps.pop_front();
                if (got !== want || m_tdata[39:38] !== 2'b00)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch: expected st=%0d vp=%h pf=%h s=%b e=%b l=%b,",
                                  " got st=%0d vp=%h pf=%h s=%b e=%b l=%b"},
                                 want.status, want.vpage, want.frame, want.run_start,
                                 want.run_end, want.last, got.status, got.vpage,
                                 got.frame, got.run_start, got.run_end, got.last);
                end
            end
        end
    end

    // Receiver stalls drawn per result; ready drops only across a stall
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        err_count   = 0;
        idle_cycles = 0;
        free_count  = FREE_W'(NUM_FRAMES);
        first_frame = FIRST_FRAME_RST;
        win_base    = WIN_BASE_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_edge_sizes();
        test_phys_exhausted();
        test_window_extremes();
        test_random_traffic();
        test_fragmentation();
        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0 && pending_maps.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/prfa_pkg.sv
rtl/core/page_run_frame_allocator_unit.sv
test/tb_top.sv
